/* sv/sha256_stream_hasher_assert.svh */
// Assertion macros for the SHA-256 stream hasher
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/sha_pkg.sv */
package sha_pkg;
	localparam int QueueDepth = 4;
	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	// queued operation from the front part to the back part
	typedef struct packed {
		logic finish;
		logic [7:0] data;
	} sha_op_t;

	typedef logic [31:0] word_t;

	function automatic word_t init_hash(input logic [2:0] i);
		case (i)
			3'd0: init_hash = 32'h6a09e667;
			3'd1: init_hash = 32'hbb67ae85;
			3'd2: init_hash = 32'h3c6ef372;
			3'd3: init_hash = 32'ha54ff53a;
			3'd4: init_hash = 32'h510e527f;
			3'd5: init_hash = 32'h9b05688c;
			3'd6: init_hash = 32'h1f83d9ab;
			default: init_hash = 32'h5be0cd19;
		endcase
	endfunction

	function automatic word_t round_k(input logic [5:0] t);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
			32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
			32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
			32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
			32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
			32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
			32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
			32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
			32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		round_k = k[t];
	endfunction

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage

/* sv/sha_if.sv */
interface sha_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [7:0] data_byte;
	modport source (output valid, req_type, data_byte, input ready);
	modport sink (input valid, req_type, data_byte, output ready);
endinterface

interface sha_dig_if;
	logic valid;
	logic ready;
	logic [31:0] digest_word;
	logic [2:0] word_index;
	logic last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* sv/sha256_stream_hasher.sv */
// channel | dir | fields
// req     | in  | req_type, data_byte
// dig     | out | digest_word, word_index, last_word
// Append beats are queued and popped while the core is idle; the 64th byte of a block
// starts compression (64 rounds of the shared round unit, then the chain add).
// Finish writes 0x80, pads one byte per cycle to the block end and compresses;
// if the length does not fit, a further pad block ending in the length and a second compression follow.
// Then 8 digest beats, one per cycle while dig.ready is high.
// Reset arst_n clears control and loads the initial hash; the queue lets the
// input side keep taking beats while the back part is busy or stalled.
module sha256_stream_hasher
	import sha_pkg::*;
#(
	parameter int Depth = QueueDepth
) (
	input logic clk,
	input logic arst_n,
	sha_req_if.sink req,
	sha_dig_if.source dig
);
	logic push, full, pop, empty;
	sha_op_t push_op, pop_op;

	sha_front u_front (.req(req), .full(full), .push(push), .push_op(push_op));

	sha_queue #(.Depth(Depth)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_op(push_op), .full(full),
		.pop(pop), .pop_op(pop_op), .empty(empty)
	);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n), .empty(empty), .op(pop_op), .pop(pop), .dig(dig)
	);
endmodule

/* sv/sha_queue.sv */
module sha_queue
	import sha_pkg::*;
#(
	parameter int Depth = QueueDepth
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input sha_op_t push_op,
	output logic full,
	input logic pop,
	output sha_op_t pop_op,
	output logic empty
);
	localparam int AW = $clog2(Depth);
	sha_op_t mem_q [Depth];
	logic [AW:0] wr_q, rd_q;

	assign full = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
	assign empty = (wr_q == rd_q);
	assign pop_op = mem_q[rd_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q[AW-1:0]] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + 1'b1;
			if (pop && !empty) rd_q <= rd_q + 1'b1;
		end
	end
endmodule

/* sv/sha_core.sv */
module sha_core
	import sha_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic empty,
	input sha_op_t op,
	output logic pop,
	sha_dig_if.source dig
);
	`include "sha256_stream_hasher_assert.svh"

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RUN = 3'd1;
	localparam logic [2:0] ST_ADD = 3'd2;
	localparam logic [2:0] ST_PAD = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [2:0] st_q;
	// block buffer as 16 big-endian words, one byte lane written per cycle
	word_t blk_q [16];
	logic [60:0] cnt_q;
	logic [63:0] bits_q;
	word_t h_q [8];
	word_t v_q [8];
	word_t w_q [16];
	logic [5:0] t_q;
	logic [5:0] pos_q;
	logic fin_q;
	// current padding block carries the bit length in bytes 56..63
	logic len_q;
	logic [2:0] oi_q;
	logic [7:0] pad_byte;

	// round datapath
	word_t w_new, s0, s1, t1, t2, wsel;
	always_comb begin
		wsel = blk_q[t_q[3:0]];
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		w_new = (t_q < 6'd16) ? wsel : s1 + w_q[9] + s0 + w_q[0];
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(t_q) + w_new;
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// zero fill, or a length byte at the tail of the length block
	assign pad_byte = (len_q && pos_q >= 6'd56) ? bits_q[{~pos_q[2:0], 3'b000} +: 8] : 8'h00;

	assign pop = (st_q == ST_IDLE) && !empty;
	assign dig.valid = (st_q == ST_OUT);
	assign dig.digest_word = h_q[oi_q];
	assign dig.word_index = oi_q;
	assign dig.last_word = (oi_q == 3'd7);

	// block buffer and length capture
	always_ff @(posedge clk) begin
		if (pop) begin
			blk_q[cnt_q[5:2]][{~cnt_q[1:0], 3'b000} +: 8] <= op.finish ? 8'h80 : op.data;
			if (op.finish) bits_q <= {cnt_q, 3'b000};
		end else if (st_q == ST_PAD) begin
			blk_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <= pad_byte;
		end
	end

	// sequencer and hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			t_q <= '0;
			pos_q <= '0;
			fin_q <= 1'b0;
			len_q <= 1'b0;
			oi_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
			for (int i = 0; i < 8; i++) v_q[i] <= '0;
			for (int i = 0; i < 16; i++) w_q[i] <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (pop) begin
						t_q <= '0;
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
						if (!op.finish) begin
							cnt_q <= cnt_q + 1'b1;
							if (cnt_q[5:0] == 6'd63) st_q <= ST_RUN;
						end else begin
							fin_q <= 1'b1;
							len_q <= (cnt_q[5:0] < 6'd56);
							pos_q <= cnt_q[5:0] + 1'b1;
							// 0x80 took the last slot: compress now, length block follows
							if (cnt_q[5:0] == 6'd63) st_q <= ST_RUN;
							else st_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == 6'd63) begin
						st_q <= ST_RUN;
						t_q <= '0;
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					end
				end
				ST_RUN: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
					w_q[15] <= w_new;
					for (int i = 7; i > 0; i--) v_q[i] <= v_q[i - 1];
					v_q[4] <= v_q[3] + t1;
					v_q[0] <= t1 + t2;
					t_q <= t_q + 1'b1;
					if (t_q == 6'd63) st_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					oi_q <= '0;
					if (!fin_q) st_q <= ST_IDLE;
					else if (len_q) st_q <= ST_OUT;
					else begin
						// padded block done, length block still to build
						len_q <= 1'b1;
						pos_q <= '0;
						st_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (dig.ready) begin
						oi_q <= oi_q + 1'b1;
						if (oi_q == 3'd7) begin
							st_q <= ST_IDLE;
							cnt_q <= '0;
							fin_q <= 1'b0;
							len_q <= 1'b0;
							for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`SHA_ASSERT_IMPL(a_out_idx, clk, arst_n, dig.valid && dig.last_word, oi_q == 3'd7)
	`SHA_ASSERT_IMPL(a_pop_idle, clk, arst_n, pop, st_q == ST_IDLE)
	`SHA_ASSERT_NEXT(a_run_steps, clk, arst_n, st_q == ST_RUN && t_q != 6'd63,
		st_q == ST_RUN)
endmodule

/* sv/sha_front.sv */
module sha_front
	import sha_pkg::*;
(
	sha_req_if.sink req,
	input logic full,
	output logic push,
	output sha_op_t push_op
);
	// classify beat into an append or finish operation
	assign req.ready = !full;
	assign push = req.valid && !full;
	assign push_op.finish = (req.req_type == REQ_FINISH);
	assign push_op.data = (req.req_type == REQ_APPEND) ? req.data_byte : 8'h00;
endmodule

/* dv/sha_hash_model.sv */
`timescale 1ns / 100ps
// Bit-accurate SHA-256 digest predictor used by the testbench
package sha_hash_model;
	import sha_pkg::*;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0] word_index;
		logic last_word;
	} digest_beat_t;

	localparam logic [31:0] RoundConst [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
		32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
		32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
		32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
		32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
		32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
		32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
		32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
		32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [31:0] StartHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	logic [31:0] hash_state [8];
	logic [7:0] msg_block [64];
	logic [60:0] msg_len;
	digest_beat_t digest_queue [$];

	function automatic logic [31:0] ror32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void clear_hash();
		hash_state = StartHash;
		msg_len = '0;
	endfunction

	// 64 rounds over msg_block into hash_state
	function automatic void absorb_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		for (int t = 0; t < 16; t++)
			w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
			s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
			w[t] = s1 + w[t-7] + s0 + w[t-16];
		end
		v = hash_state;
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
				((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w[t];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
				((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int j = 7; j > 0; j--)
				v[j] = v[j-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int j = 0; j < 8; j++)
			hash_state[j] += v[j];
	endfunction

	// apply one accepted request; finish pushes eight digest beats
	function automatic void hash_request(logic kind, logic [7:0] data);
		int pos;
		logic [63:0] bits;
		digest_beat_t b;
		pos = msg_len[5:0];
		if (kind == REQ_APPEND) begin
			msg_block[pos] = data;
			msg_len = msg_len + 61'd1;
			if (pos == 63)
				absorb_block();
			return;
		end
		bits = {msg_len, 3'b000};
		msg_block[pos] = 8'h80;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				msg_block[pos] = 8'h00;
				pos++;
			end
			absorb_block();
			pos = 0;
		end
		while (pos < 56) begin
			msg_block[pos] = 8'h00;
			pos++;
		end
		for (int j = 0; j < 8; j++)
			msg_block[56+j] = bits[63-8*j -: 8];
		absorb_block();
		for (int j = 0; j < 8; j++) begin
			b.digest_word = hash_state[j];
			b.word_index = j[2:0];
			b.last_word = (j == 7);
			digest_queue.push_back(b);
		end
		clear_hash();
	endfunction
endpackage

/* dv/testbench.sv */
`timescale 1ns / 100ps
module testbench;
	import sha_pkg::*;
	import sha_hash_model::*;

	logic clk;
	logic arst_n;
	int mismatch_count;
	int stall_mode;

	sha_req_if req ();
	sha_dig_if dig ();

	sha256_stream_hasher uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.dig(dig.source)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// one request beat: hold until accepted; valid stays up for the next beat
	task automatic send_req(logic kind, logic [7:0] data);
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.data_byte <= data;
		do @(posedge clk); while (!req.ready);
		hash_request(kind, data);
		@(negedge clk);
	endtask

	// idle gap on the request side
	task automatic pause_req(int cycles);
		req.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// bursts with random gaps
	task automatic send_msg(int len, bit all_same = 0, logic [7:0] fill = 8'h00);
		int burst;
		burst = 0;
		for (int i = 0; i <= len; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				if ($urandom_range(0, 2) == 0)
					pause_req($urandom_range(1, 6));
			end
			burst--;
			if (i == len)
				send_req(REQ_FINISH, 8'($urandom));
			else
				send_req(REQ_APPEND, all_same ? fill : 8'($urandom));
		end
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		do @(negedge clk); while (digest_queue.size() != 0);
	endtask

	task automatic test_directed();
		send_req(REQ_FINISH, 8'hff);                 // empty message
		send_req(REQ_APPEND, 8'h61);                 // "abc"
		send_req(REQ_APPEND, 8'h62);
		send_req(REQ_APPEND, 8'h63);
		send_req(REQ_FINISH, 8'h00);
		send_req(REQ_FINISH, 8'h00);                 // back-to-back finish
		send_req(REQ_APPEND, 8'h00);
		send_req(REQ_APPEND, 8'hff);
		send_req(REQ_FINISH, 8'h55);
		wait_drained();
	endtask

	// lengths around the padding boundaries and block edge
	task automatic test_boundaries();
		int lens [4] = '{55, 56, 63, 64};
		foreach (lens[i])
			send_msg(lens[i], 1'b1, (i % 2) ? 8'hff : 8'h00);
	endtask

	task automatic test_random(int budget);
		int sent;
		int len;
		sent = 0;
		while (sent < budget) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80)
				: $urandom_range(0, 40);
			if (len > budget - sent - 1)
				len = budget - sent - 1;
			send_msg(len);
			sent += len + 1;
			if ($urandom_range(0, 7) == 0)
				wait_drained();
		end
	endtask

	// receiver stall pattern, changed per phase
	always @(negedge clk) begin
		if (!arst_n)
			dig.ready <= 1'b0;
		else
			case (stall_mode)
			0: dig.ready <= 1'b1;
			1: dig.ready <= ($urandom_range(0, 3) != 0);
			default: dig.ready <= ($urandom_range(0, 9) < 3);
			endcase
	end

	// digest checker
	always @(posedge clk) begin
		digest_beat_t want;
		if (arst_n && dig.valid && dig.ready) begin
			if (digest_queue.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected digest beat %h idx %0d", dig.digest_word,
						dig.word_index);
			end else begin
				want = digest_queue.pop_front();
				if (want.digest_word !== dig.digest_word ||
					want.word_index !== dig.word_index ||
					want.last_word !== dig.last_word) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
							want.digest_word, want.word_index, want.last_word,
							dig.digest_word, dig.word_index, dig.last_word);
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		mismatch_count = 0;
		stall_mode = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = REQ_APPEND;
		req.data_byte = 8'h00;
		clear_hash();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		stall_mode = 1;
		test_boundaries();
		stall_mode = 2;
		test_random(60);
		stall_mode = 1;
		test_random(50);
		wait_drained();
		repeat (200) @(negedge clk);
		if (mismatch_count == 0 && digest_queue.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
